[hdl/cfmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfmc_pkg
// Shared types, constants and hash helpers for the COBS frame receiver.
// ----------------------------------------------------------------------------
package cfmc_pkg;

	localparam int MaxFrameDefault = 256;
	localparam int MinFrame        = 6;

	localparam logic [31:0] C1 = 32'hcc9e2d51;
	localparam logic [31:0] C2 = 32'h1b873593;
	localparam logic [31:0] F1 = 32'h85ebca6b;
	localparam logic [31:0] F2 = 32'hc2b2ae35;
	localparam logic [31:0] HAdd = 32'he6546b64;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_LONG     = 3'd2;
	localparam logic [2:0] ST_COBS     = 3'd3;
	localparam logic [2:0] ST_MISMATCH = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,    // wait for a byte
		S_BYTE,    // run byte update
		S_BMUL1,   // block: k * C1
		S_BMUL2,   // block: rotl, * C2
		S_BMIX,    // block: mix into hash
		S_FTAIL1,  // finish: tail k * C1
		S_FTAIL2,  // finish: rotl, * C2
		S_FXOR,    // finish: xor length, fold 16
		S_FMUL1,   // finish: * F1
		S_FMUL2,   // finish: fold 13, * F2
		S_FCMP,    // finish: fold 16, compare
		S_OUT      // hold result until taken
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_BYTE, OP_BMUL1, OP_BMUL2, OP_BMIX,
		OP_FTAIL1, OP_FTAIL2, OP_FXOR, OP_FMUL1, OP_FMUL2, OP_FCMP
	} op_t;

	typedef struct packed {
		logic delim;      // latched byte is the delimiter
		logic emit;       // byte step produced an item
		logic block_full; // a fourth payload byte completed a block
		logic do_hash;    // delimiter verdict needs the hash
		logic tail;       // payload length not multiple of four
	} stat_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
		rotl = (x << r) | (x >> (32 - r));
	endfunction

endpackage

[hdl/cfmc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfmc_datapath
// Frame state, COBS decode, delay line and a shared 32x32 multiplier
// for the MurmurHash3 block mix and finalizer.
// ----------------------------------------------------------------------------
module cfmc_datapath #(
	parameter int MAX_FRAME = cfmc_pkg::MaxFrameDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfmc_pkg::op_t     op,
	input  logic [7:0]        in_byte,
	input  logic              load,
	input  logic              pcnt_clr,
	input  logic [31:0]       hash_seed,
	output cfmc_pkg::stat_t   stat,
	output logic [7:0]        out_byte,
	output logic              frame_end,
	output logic [2:0]        frame_status,
	output logic [7:0]        payload_length
);

	localparam logic [8:0] LastPos = 9'(MAX_FRAME - 1);

	logic [7:0]  byte_q;
	logic [8:0]  fcount_q;
	logic        ovf_q;
	logic [7:0]  cd_q;
	logic [7:0]  dl_q [4];
	logic [31:0] hash_q, seed_q, t_q;
	logic [23:0] acc_q;
	logic [7:0]  pcnt_q;
	logic        emit_q, full_q, end_q;
	logic [2:0]  status_q;
	logic [7:0]  ob_q;

	logic [31:0] mul_a, mul_b, mul_p;
	logic [7:0]  cd_dec;
	logic [31:0] rx;
	logic        emit_d, full_d;

	assign cd_dec = cd_q - 8'd1;
	assign rx = {dl_q[0], dl_q[1], dl_q[2], dl_q[3]};

	// A data byte past the fourth decoded byte releases one payload item
	assign emit_d = (byte_q != 8'd0) && !ovf_q && (fcount_q < LastPos)
		&& (fcount_q >= 9'd5);
	assign full_d = emit_d && (pcnt_q[1:0] == 2'd3);

	// Select multiplier operands
	always_comb begin
		mul_a = t_q;
		mul_b = cfmc_pkg::C1;
		unique case (op) inside
			cfmc_pkg::OP_BMUL2, cfmc_pkg::OP_FTAIL2: begin
				mul_a = cfmc_pkg::rotl(t_q, 15);
				mul_b = cfmc_pkg::C2;
			end
			cfmc_pkg::OP_FMUL1: mul_b = cfmc_pkg::F1;
			cfmc_pkg::OP_FMUL2: begin
				mul_a = t_q ^ (t_q >> 13);
				mul_b = cfmc_pkg::F2;
			end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign stat.delim      = (byte_q == 8'd0);
	assign stat.emit       = emit_q;
	assign stat.block_full = full_q;
	assign stat.do_hash    = !ovf_q && (fcount_q >= 9'(cfmc_pkg::MinFrame - 1))
		&& (cd_q == 8'd1);
	assign stat.tail       = (pcnt_q[1:0] != 2'd0);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcount_q <= '0;
			ovf_q    <= 1'b0;
			cd_q     <= '0;
			pcnt_q   <= '0;
			acc_q    <= '0;
			emit_q   <= 1'b0;
			full_q   <= 1'b0;
			seed_q   <= '0;
			end_q    <= 1'b0;
			status_q <= cfmc_pkg::ST_OK;
		end else begin
			if (load) seed_q <= hash_seed;
			unique case (op)
				cfmc_pkg::OP_BYTE: begin
					emit_q <= emit_d;
					full_q <= full_d;
					end_q  <= (byte_q == 8'd0);
					// Verdict without hash; hashing path overwrites status later
					if (byte_q != 8'd0) status_q <= cfmc_pkg::ST_OK;
					else if (ovf_q) status_q <= cfmc_pkg::ST_LONG;
					else if (fcount_q < 9'(cfmc_pkg::MinFrame - 1))
						status_q <= cfmc_pkg::ST_SHORT;
					else if (cd_q != 8'd1) status_q <= cfmc_pkg::ST_COBS;
					else status_q <= cfmc_pkg::ST_OK;
					if (byte_q != 8'd0 && !ovf_q) begin
						if (fcount_q >= LastPos) begin
							ovf_q <= 1'b1;
						end else begin
							fcount_q <= fcount_q + 9'd1;
							if (fcount_q == 9'd0) begin
								cd_q   <= byte_q;
								acc_q  <= '0;
								pcnt_q <= '0;
							end else begin
								cd_q <= (cd_dec == 8'd0) ? byte_q : cd_dec;
								if (fcount_q >= 9'd5) begin
									pcnt_q <= pcnt_q + 8'd1;
									if (pcnt_q[1:0] != 2'd3) begin
										unique case (pcnt_q[1:0])
											2'd0: acc_q[7:0]   <= dl_q[0];
											2'd1: acc_q[15:8]  <= dl_q[0];
											default: acc_q[23:16] <= dl_q[0];
										endcase
									end
								end
							end
						end
					end
				end
				cfmc_pkg::OP_BMIX: acc_q <= '0;
				cfmc_pkg::OP_FCMP: begin
					status_q <= ((t_q ^ (t_q >> 16)) == rx) ?
						cfmc_pkg::ST_OK : cfmc_pkg::ST_MISMATCH;
				end
				default: ;
			endcase
			// Clear frame after verdict is formed
			if (op == cfmc_pkg::OP_FCMP ||
				(op == cfmc_pkg::OP_BYTE && byte_q == 8'd0)) begin
				fcount_q <= '0;
				ovf_q    <= 1'b0;
				cd_q     <= '0;
			end
			// Drop payload count and pending bytes once the verdict is taken
			if (pcnt_clr) begin
				pcnt_q <= '0;
				acc_q  <= '0;
			end
		end
	end

	// Payload registers: byte latch, delay line, hash
	always_ff @(posedge clk) begin
		if (load) byte_q <= in_byte;
		unique case (op) inside
			cfmc_pkg::OP_BYTE: begin
				ob_q <= dl_q[0];
				if (byte_q != 8'd0 && !ovf_q && fcount_q < LastPos) begin
					if (fcount_q == 9'd0) begin
						hash_q <= seed_q;
					end else begin
						dl_q[0] <= dl_q[1];
						dl_q[1] <= dl_q[2];
						dl_q[2] <= dl_q[3];
						dl_q[3] <= (cd_dec == 8'd0) ? 8'd0 : byte_q;
					end
				end
				// Load block word (tail word on the delimiter) before multiply
				t_q <= (byte_q == 8'd0) ? {8'd0, acc_q} : {dl_q[0], acc_q};
			end
			cfmc_pkg::OP_BMUL1, cfmc_pkg::OP_BMUL2,
			cfmc_pkg::OP_FTAIL1, cfmc_pkg::OP_FTAIL2,
			cfmc_pkg::OP_FMUL1, cfmc_pkg::OP_FMUL2: t_q <= mul_p;
			cfmc_pkg::OP_BMIX: hash_q <= cfmc_pkg::rotl(hash_q ^ t_q, 13) * 32'd5
				+ cfmc_pkg::HAdd;
			cfmc_pkg::OP_FXOR: begin
				t_q <= (hash_q ^ {24'd0, pcnt_q}) ^ ((hash_q ^ {24'd0, pcnt_q}) >> 16);
			end
			default: ;
		endcase
		if (op == cfmc_pkg::OP_FTAIL2) hash_q <= hash_q ^ mul_p;
	end

	assign out_byte       = end_q ? 8'd0 : ob_q;
	assign frame_end      = end_q;
	assign frame_status   = end_q ? status_q : 3'd0;
	assign payload_length = end_q ? pcnt_q : 8'd0;

endmodule

[hdl/cfmc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfmc_ctrl
// Sequencer: accepts a byte, steps the datapath, hands out results.
// ----------------------------------------------------------------------------
module cfmc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  cfmc_pkg::stat_t stat,
	output cfmc_pkg::op_t   op,
	output logic            load,
	output logic            pcnt_clr
);

	cfmc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= cfmc_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		op        = cfmc_pkg::OP_NONE;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		load      = 1'b0;
		pcnt_clr  = 1'b0;
		unique case (state_q)
			cfmc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					load = 1'b1;
					state_d = cfmc_pkg::S_BYTE;
				end
			end
			cfmc_pkg::S_BYTE: begin
				op = cfmc_pkg::OP_BYTE;
				if (stat.delim) begin
					if (stat.do_hash)
						state_d = stat.tail ? cfmc_pkg::S_FTAIL1 : cfmc_pkg::S_FXOR;
					else state_d = cfmc_pkg::S_OUT;
				end else state_d = cfmc_pkg::S_OUT;
			end
			cfmc_pkg::S_BMUL1: begin op = cfmc_pkg::OP_BMUL1; state_d = cfmc_pkg::S_BMUL2; end
			cfmc_pkg::S_BMUL2: begin op = cfmc_pkg::OP_BMUL2; state_d = cfmc_pkg::S_BMIX; end
			cfmc_pkg::S_BMIX: begin op = cfmc_pkg::OP_BMIX; state_d = cfmc_pkg::S_IDLE; end
			cfmc_pkg::S_FTAIL1: begin
				op = cfmc_pkg::OP_FTAIL1; state_d = cfmc_pkg::S_FTAIL2;
			end
			cfmc_pkg::S_FTAIL2: begin
				op = cfmc_pkg::OP_FTAIL2; state_d = cfmc_pkg::S_FXOR;
			end
			cfmc_pkg::S_FXOR: begin op = cfmc_pkg::OP_FXOR; state_d = cfmc_pkg::S_FMUL1; end
			cfmc_pkg::S_FMUL1: begin op = cfmc_pkg::OP_FMUL1; state_d = cfmc_pkg::S_FMUL2; end
			cfmc_pkg::S_FMUL2: begin op = cfmc_pkg::OP_FMUL2; state_d = cfmc_pkg::S_FCMP; end
			cfmc_pkg::S_FCMP: begin op = cfmc_pkg::OP_FCMP; state_d = cfmc_pkg::S_OUT; end
			cfmc_pkg::S_OUT: begin
				// Delimiter always yields an item; data bytes only when emitted
				if (!stat.delim && !stat.emit) begin
					state_d = cfmc_pkg::S_IDLE;
				end else begin
					out_valid = 1'b1;
					if (out_ready) begin
						if (!stat.delim && stat.block_full) state_d = cfmc_pkg::S_BMUL1;
						else begin
							state_d = cfmc_pkg::S_IDLE;
							pcnt_clr = stat.delim;
						end
					end
				end
			end
			default: state_d = cfmc_pkg::S_IDLE;
		endcase
	end

endmodule

[hdl/cobs_frame_receiver_murmur_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobs_frame_receiver_murmur_check
// COBS deframer with a MurmurHash3-32 trailer check.
// ----------------------------------------------------------------------------
// Usage:
//   Raw link bytes enter on in_valid/in_ready (in_byte); zero ends a frame.
//   Decoded payload items leave on out_valid/out_ready with frame_end low;
//   one verdict item (frame_end high, frame_status, payload_length) closes
//   each frame. Payload goes out before its verdict: drop a frame whose
//   status is not ok.
//   hash_seed is written by cfg_we/cfg_data, only while idle (a rule for the user,
//   not enforced by the block); it is taken at the first byte of each frame.
// Sequence:
//   A plain byte steps through accept, update and output. Every fourth
//   payload byte adds the block mix (BMUL1, BMUL2, BMIX) on the shared 32x32
//   multiplier; a checked delimiter adds the finalizer (FTAIL1 and FTAIL2 when
//   a tail is left, then FXOR, FMUL1, FMUL2, FCMP). One item is in flight at
//   a time; a stalled output holds the block with in_ready low.
// Reset:
//   arst_n clears frame state and the seed; the block is ready at once.
// ----------------------------------------------------------------------------
module cobs_frame_receiver_murmur_check #(
	parameter int MAX_FRAME = cfmc_pkg::MaxFrameDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        frame_end,
	output logic [2:0]  frame_status,
	output logic [7:0]  payload_length,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data
);

	logic [31:0]     seed_q;
	cfmc_pkg::op_t   op;
	cfmc_pkg::stat_t stat;
	logic            load, pcnt_clr;

	// Seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seed_q <= '0;
		else if (cfg_we) seed_q <= cfg_data;
	end

	cfmc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.stat, .op, .load, .pcnt_clr
	);

	cfmc_datapath #(.MAX_FRAME(MAX_FRAME)) u_dp (
		.clk, .arst_n, .op, .in_byte, .load, .pcnt_clr, .hash_seed(seed_q), .stat,
		.out_byte, .frame_end, .frame_status, .payload_length
	);

	// No new byte while a result is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while output pending");
	a_end_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end |-> frame_status == cfmc_pkg::ST_OK)
		else $error("status on payload item");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_status <= cfmc_pkg::ST_MISMATCH)
		else $error("bad status code");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("output dropped");

endmodule
